// File: hdl/idwi_pkg.sv
// Shared constants for the inverse distance weighted index unit.
package idwi_pkg;

  // Default configuration
  localparam int DEF_INDEX_BITS     = 10;
  localparam int DEF_FRAC_BITS      = 16;
  localparam int DEF_MAX_NEIGHBOURS = 8;

  // Fixed datapath widths
  localparam int COORD_W  = 32;  // Q16.16 coordinate
  localparam int DIFF_W   = 33;  // coordinate difference / magnitude
  localparam int SQ_W     = 66;  // squared distance
  localparam int ROOT_W   = 33;  // distance
  localparam int WEIGHT_W = 48;  // Q16.32 weight
  localparam int SUM_W    = 64;  // weighted index sums
  localparam int LANES    = 3;   // x, y, z

endpackage

// File: hdl/inverse_distance_weighted_index_unit.sv
// Top level of the inverse distance weighted (Shepard) mean voxel index unit.
//
// Input stream (s_*): one beat per neighbour sample of a query: query point,
// sample point (signed Q16.16) and the sample's voxel index in s_tdata; s_tlast
// marks the final neighbour of the query. Output stream (m_*): one beat per
// query, the weighted mean index (unsigned INDEX_BITS.FRAC_BITS) per axis in
// m_tdata and an exact-hit flag in m_tuser.
// One sample is worked on at a time, in the order accept, absolute value,
// serial squarers, sum, zero test, two-bits-per-cycle square root, the serial
// divider that forms the weight, the serial index product and accumulation.
// A coincident sample stops after the zero test. Samples beyond MAX_NEIGHBOURS
// are taken without processing. Closing a query adds a final step and the
// hand-over to the output register, plus a serial mean division when no
// coincident sample was seen and the weight sum is nonzero.
// Result appears in an output register; the next query's samples are accepted
// while it waits. If the receiver stalls, a second completed query waits and
// s_tready stays low until the output register frees.
// Reset (rst, synchronous) clears the sums, the counters and the output valid.
module inverse_distance_weighted_index_unit #(
  parameter int INDEX_BITS     = idwi_pkg::DEF_INDEX_BITS,
  parameter int FRAC_BITS      = idwi_pkg::DEF_FRAC_BITS,
  parameter int MAX_NEIGHBOURS = idwi_pkg::DEF_MAX_NEIGHBOURS,
  localparam int IN_W   = 6 * idwi_pkg::COORD_W + 3 * INDEX_BITS,
  localparam int IN_PW  = ((IN_W + 7) / 8) * 8,
  localparam int MEAN_W = INDEX_BITS + FRAC_BITS,
  localparam int OUT_W  = 3 * MEAN_W,
  localparam int OUT_PW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // query_x, query_y, query_z, sample_x, sample_y, sample_z, voxel_x, voxel_y, voxel_z
  input  logic [IN_PW-1:0]  s_tdata,
  input  logic              s_tlast,  // last_sample
  output logic              m_tvalid,
  input  logic              m_tready,
  // mean_x, mean_y, mean_z
  output logic [OUT_PW-1:0] m_tdata,
  output logic              m_tuser   // exact_hit
);

  localparam int CW     = idwi_pkg::COORD_W;
  localparam int DW     = idwi_pkg::DIFF_W;
  localparam int SQW    = idwi_pkg::SQ_W;
  localparam int RW     = idwi_pkg::ROOT_W;
  localparam int WW     = idwi_pkg::WEIGHT_W;
  localparam int SW     = idwi_pkg::SUM_W;
  localparam int NL     = idwi_pkg::LANES;
  localparam int PW     = WW + INDEX_BITS;
  localparam int WNUM_W = WW + 1;
  localparam int MNUM_W = SW + FRAC_BITS;
  localparam int CNT_W  = $clog2(MNUM_W);
  localparam int NB_W   = $clog2(MAX_NEIGHBOURS + 1);

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_ABS  = 11'b00000000010,
    ST_SQR  = 11'b00000000100,
    ST_SUM  = 11'b00000001000,
    ST_TEST = 11'b00000010000,
    ST_ROOT = 11'b00000100000,
    ST_DIVW = 11'b00001000000,
    ST_PROD = 11'b00010000000,
    ST_ACC  = 11'b00100000000,
    ST_FIN  = 11'b01000000000,
    ST_MEAN = 11'b10000000000
  } state_t;

  state_t state;
  logic   emit;  // a finished query waits for the output register

  logic [CNT_W-1:0] cnt;
  logic [NB_W-1:0]  count;
  logic             last_q;

  // per-sample payload
  logic signed [DW-1:0] diff [NL];
  logic [DW-1:0]         mag  [NL];
  logic [DW-1:0]         mpl  [NL];
  logic [RW-1:0]         p_hi [NL];
  logic [RW-1:0]         p_lo [NL];
  logic [INDEX_BITS-1:0] vox  [NL];
  logic [SQW-1:0]        ssum;
  logic [RW-1:0]         root;
  logic [RW:0]           rrem;
  logic [PW-1:0]         pacc [NL];
  logic [PW-1:0]         wsh  [NL];
  logic [INDEX_BITS-1:0] vsh  [NL];
  logic [WW-1:0]         w;

  // query state
  logic [WW-1:0]         wsum;
  logic [SW-1:0]         wacc [NL];
  logic                  hit_seen;
  logic [INDEX_BITS-1:0] hit_vox [NL];

  // divider lanes
  logic              wdiv_load, wdiv_step;
  logic [WNUM_W-1:0] wquo;
  logic              mdiv_load, mdiv_step;
  logic [MNUM_W-1:0] mquo [NL];

  logic [RW+2:0]     rrem_sh, rtrial, rrem_sub;
  logic              rge;
  logic              out_free;
  logic [MEAN_W-1:0] mean_v [NL];
  logic              accept;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE) && !emit;
  assign out_free  = !m_tvalid || m_tready;
  assign wdiv_load = (state == ST_ROOT) && (cnt == CNT_W'(RW - 1));
  assign wdiv_step = (state == ST_DIVW);
  assign mdiv_load = (state == ST_FIN) && !hit_seen && (wsum != '0);
  assign mdiv_step = (state == ST_MEAN);

  // square root: two radicand bits per step
  always_comb begin
    rrem_sh  = {rrem, ssum[SQW-1:SQW-2]};
    rtrial   = {1'b0, root, 2'b01};
    rge      = (rrem_sh >= rtrial);
    rrem_sub = rrem_sh - rtrial;
  end

  idwi_div_lane #(.NUM_W(WNUM_W), .DEN_W(RW)) u_wdiv (
    .clk  (clk),
    .load (wdiv_load),
    .step (wdiv_step),
    .num  ({1'b1, {WW{1'b0}}}),
    .den  ({root[RW-2:0], rge}),
    .quo  (wquo)
  );

  for (genvar k = 0; k < NL; k++) begin : g_mean
    idwi_div_lane #(.NUM_W(MNUM_W), .DEN_W(WW)) u_mdiv (
      .clk  (clk),
      .load (mdiv_load),
      .step (mdiv_step),
      .num  ({wacc[k], {FRAC_BITS{1'b0}}}),
      .den  (wsum),
      .quo  (mquo[k])
    );

    // final mean: exact hit, empty sums, saturation
    always_comb begin
      if (hit_seen) begin
        mean_v[k] = {hit_vox[k], {FRAC_BITS{1'b0}}};
      end else if (wsum == '0) begin
        mean_v[k] = '0;
      end else if (mquo[k][MNUM_W-1:MEAN_W] != '0) begin
        mean_v[k] = '1;
      end else begin
        mean_v[k] = mquo[k][MEAN_W-1:0];
      end
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      emit     <= 1'b0;
      cnt      <= '0;
      count    <= '0;
      hit_seen <= 1'b0;
      wsum     <= '0;
      m_tvalid <= 1'b0;
      for (int k = 0; k < NL; k++) wacc[k] <= '0;
    end else begin
      // hand a finished query to the output register and clear the sums
      if (emit && out_free) begin
        emit     <= 1'b0;
        m_tvalid <= 1'b1;
        m_tdata  <= OUT_PW'({mean_v[2], mean_v[1], mean_v[0]});
        m_tuser  <= hit_seen;
        count    <= '0;
        hit_seen <= 1'b0;
        wsum     <= '0;
        for (int k = 0; k < NL; k++) wacc[k] <= '0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            last_q <= s_tlast;
            for (int k = 0; k < NL; k++) begin
              diff[k] <= DW'($signed(s_tdata[(k+3)*CW +: CW]))
                       - DW'($signed(s_tdata[k*CW +: CW]));
              vox[k]  <= s_tdata[6*CW + k*INDEX_BITS +: INDEX_BITS];
            end
            if (count < NB_W'(MAX_NEIGHBOURS)) begin
              state <= ST_ABS;
            end else if (s_tlast) begin
              state <= ST_FIN;
            end
          end
        end
        ST_ABS: begin
          for (int k = 0; k < NL; k++) begin
            mag[k]  <= diff[k][DW-1] ? DW'(-diff[k]) : DW'(diff[k]);
            mpl[k]  <= diff[k][DW-1] ? DW'(-diff[k]) : DW'(diff[k]);
            p_hi[k] <= '0;
            p_lo[k] <= '0;
          end
          cnt   <= '0;
          state <= ST_SQR;
        end
        ST_SQR: begin
          // serial square, one multiplier bit per cycle
          for (int k = 0; k < NL; k++) begin
            logic [RW:0] ps;
            ps      = {1'b0, p_hi[k]} + (mpl[k][0] ? {1'b0, mag[k]} : '0);
            p_hi[k] <= ps[RW:1];
            p_lo[k] <= {ps[0], p_lo[k][RW-1:1]};
            mpl[k]  <= mpl[k] >> 1;
          end
          if (cnt == CNT_W'(DW - 1)) begin
            cnt   <= '0;
            state <= ST_SUM;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_SUM: begin
          // two adds, one after the other
          if (cnt == '0) begin
            ssum <= {p_hi[0], p_lo[0]} + {p_hi[1], p_lo[1]};
            cnt  <= cnt + 1'b1;
          end else begin
            ssum  <= ssum + {p_hi[2], p_lo[2]};
            state <= ST_TEST;
          end
        end
        ST_TEST: begin
          count <= count + 1'b1;
          cnt   <= '0;
          root  <= '0;
          rrem  <= '0;
          if (ssum == '0) begin
            if (!hit_seen) begin
              hit_seen <= 1'b1;
              for (int k = 0; k < NL; k++) hit_vox[k] <= vox[k];
            end
            state <= last_q ? ST_FIN : ST_IDLE;
          end else begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          rrem <= rge ? rrem_sub[RW:0] : rrem_sh[RW:0];
          root <= {root[RW-2:0], rge};
          ssum <= ssum << 2;
          if (cnt == CNT_W'(RW - 1)) begin
            cnt   <= '0;
            state <= ST_DIVW;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIVW: begin
          if (cnt == CNT_W'(WNUM_W - 1)) begin
            cnt   <= '0;
            state <= ST_PROD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_PROD: begin
          // serial weight times index, one index bit per cycle
          if (cnt == '0) begin
            w <= wquo[WW] ? '1 : wquo[WW-1:0];
            for (int k = 0; k < NL; k++) begin
              pacc[k] <= '0;
              wsh[k]  <= PW'(wquo[WW] ? {WW{1'b1}} : wquo[WW-1:0]);
              vsh[k]  <= vox[k];
            end
            cnt <= cnt + 1'b1;
          end else begin
            for (int k = 0; k < NL; k++) begin
              pacc[k] <= pacc[k] + (vsh[k][0] ? wsh[k] : '0);
              wsh[k]  <= wsh[k] << 1;
              vsh[k]  <= vsh[k] >> 1;
            end
            if (cnt == CNT_W'(INDEX_BITS)) begin
              cnt   <= '0;
              state <= ST_ACC;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        ST_ACC: begin
          // saturating accumulation
          begin
            logic [WW:0] ws;
            logic [SW:0] xs;
            ws   = {1'b0, wsum} + {1'b0, w};
            wsum <= ws[WW] ? '1 : ws[WW-1:0];
            for (int k = 0; k < NL; k++) begin
              xs      = {1'b0, wacc[k]} + (SW + 1)'(pacc[k]);
              wacc[k] <= xs[SW] ? '1 : xs[SW-1:0];
            end
          end
          state <= last_q ? ST_FIN : ST_IDLE;
        end
        ST_FIN: begin
          cnt <= '0;
          if (mdiv_load) begin
            state <= ST_MEAN;
          end else begin
            emit  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_MEAN: begin
          if (cnt == CNT_W'(MNUM_W - 1)) begin
            cnt   <= '0;
            emit  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // neighbour count never passes its limit
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count <= NB_W'(MAX_NEIGHBOURS))
    else $error("neighbour count beyond limit");

  // an accepted sample under the limit starts the distance pipeline
  a_start: assert property (@(posedge clk) disable iff (rst)
    (accept && count < NB_W'(MAX_NEIGHBOURS)) |=> state == ST_ABS)
    else $error("accepted sample not processed");

  // handing over a result clears the query state
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (emit && out_free) |=> (!hit_seen && wsum == '0))
    else $error("query state not cleared after result");

  // a latched hit implies at least one counted neighbour
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    hit_seen |-> count != '0)
    else $error("hit without neighbour");

endmodule

// File: hdl/idwi_div_lane.sv
// Bit-serial restoring divider lane: one quotient bit per step.
module idwi_div_lane #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 33
) (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] d;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  // shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh  = {rem, q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, d};
    ge      = (rem_sh >= {1'b0, d});
  end

  // dividend leaves the top of q as quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (load) begin
      q   <= num;
      rem <= '0;
      d   <= den;
    end else if (step) begin
      rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      q   <= {q[NUM_W-2:0], ge};
    end
  end

  assign quo = q;

endmodule
